[hdl/vfts_pkg.sv]
`timescale 1ns / 1ps
package vfts_pkg;
   localparam int GRID_NX_DEF = 32;
   localparam int GRID_NY_DEF = 32;
   localparam int GRID_NZ_DEF = 32;
   localparam int ADDR_W = 15;
   localparam int STORE_DEPTH = 32768;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_ORIGIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_ORIGIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_ORIGIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SCALE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SCALE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_SCALE  = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MAP, ST_MAP2, ST_CHECK, ST_FETCH, ST_LERP, ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;      // capture request word
      logic       do_write;  // write grid entry
      logic [1:0] map_axis;  // axis whose coordinate is mapped
      logic       map_mul;   // multiply step
      logic       map_fin;   // finish step
      logic [2:0] corner;    // corner being read
      logic       acc_en;    // consume read data
      logic [2:0] acc_corner;
      logic       lerp_en;   // run one lerp step
      logic [2:0] lerp_step;
      logic       respond;
   } cmd_type;

   typedef struct packed {
      logic is_sample;
      logic in_grid;
      logic interior;
   } sts_type;
endpackage

[hdl/vector_field_trilinear_sampler.sv]
`timescale 1ns / 1ps
// channel  | ports                 | handshake
// req      | req_action .. pos_z   | start & !busy
// rsp      | rsp_out_* inside_res  | rsp_strobe, one cycle, no stall
// csr      | csr_index, csr_data   | csr_valid & csr_ready
// A write word passes the accept state and a write state. A sample word runs
// the axis map (one 33x32 multiply and one range check per axis), a check state,
// 8 corner reads from the single-ported grid memory, a wait for the last read and
// 7 lerp steps; busy holds off the next word until the result. Disabled or outside
// samples skip the reads, edge samples read one node. Reset is synchronous; the
// grid memory is not cleared. The receiver cannot stall the result word.
module vector_field_trilinear_sampler
   import vfts_pkg::*;
#(
   parameter int GRID_NX = GRID_NX_DEF,
   parameter int GRID_NY = GRID_NY_DEF,
   parameter int GRID_NZ = GRID_NZ_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic [ADDR_W-1:0]  req_entry_address,
   input  logic signed [31:0] req_entry_x,
   input  logic signed [31:0] req_entry_y,
   input  logic signed [31:0] req_entry_z,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_inside_res
);
   cmd_type cmd;
   sts_type sts;

   // always take configuration words
   assign csr_ready = 1'b1;

   vfts_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .cmd(cmd), .sts(sts)
   );

   vfts_datapath #(.GRID_NX(GRID_NX), .GRID_NY(GRID_NY), .GRID_NZ(GRID_NZ)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_action(req_action), .req_entry_address(req_entry_address),
      .req_entry_x(req_entry_x), .req_entry_y(req_entry_y), .req_entry_z(req_entry_z),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_strobe(rsp_strobe), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z), .rsp_inside_res(rsp_inside_res)
   );
endmodule

[hdl/vfts_ram.sv]
`timescale 1ns / 1ps
module vfts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end
   assign rdata = rdata_ff;
endmodule

[hdl/vfts_ctrl.sv]
`timescale 1ns / 1ps
module vfts_ctrl
   import vfts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd,
   input  sts_type sts
);
   state_type state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] axis_ff, axis_in;
   logic       pend_ff, pend_in;
   logic [2:0] pcor_ff, pcor_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         axis_ff <= '0;
         pend_ff <= 1'b0;
         pcor_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         axis_ff <= axis_in;
         pend_ff <= pend_in;
         pcor_ff <= pcor_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      axis_in = axis_ff;
      pend_in = 1'b0;
      pcor_in = pcor_ff;
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      cmd.acc_en = pend_ff;
      cmd.acc_corner = pcor_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start) begin
               state_in = ST_MAP;
               axis_in = 2'd0;
            end
         end
         ST_MAP: begin
            if (!sts.is_sample) begin
               cmd.do_write = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.map_axis = axis_ff;
               cmd.map_mul = 1'b1;
               state_in = ST_MAP2;
            end
         end
         ST_MAP2: begin
            cmd.map_axis = axis_ff;
            cmd.map_fin = 1'b1;
            if (axis_ff == 2'd2) state_in = ST_CHECK;
            else begin
               axis_in = axis_ff + 2'd1;
               state_in = ST_MAP;
            end
         end
         ST_CHECK: begin
            cnt_in = '0;
            if (!sts.in_grid || !sts.interior) begin
               // single node read or zero result
               cmd.corner = '0;
               pend_in = sts.in_grid;
               pcor_in = '0;
               state_in = ST_DONE;
            end else state_in = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.corner = cnt_ff;
            pend_in = 1'b1;
            pcor_in = cnt_ff;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = ST_LERP;
               cnt_in = '0;
            end
         end
         ST_LERP: begin
            if (!pend_ff) begin
               cmd.lerp_en = 1'b1;
               cmd.lerp_step = cnt_ff;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd6) state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!pend_ff) begin
               cmd.respond = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[hdl/vfts_datapath.sv]
`timescale 1ns / 1ps
module vfts_datapath
   import vfts_pkg::*;
#(
   parameter int GRID_NX = GRID_NX_DEF,
   parameter int GRID_NY = GRID_NY_DEF,
   parameter int GRID_NZ = GRID_NZ_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic               req_action,
   input  logic [ADDR_W-1:0]  req_entry_address,
   input  logic signed [31:0] req_entry_x,
   input  logic signed [31:0] req_entry_y,
   input  logic signed [31:0] req_entry_z,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic               csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_inside_res
);
   // configuration
   logic        en_ff;
   logic [31:0] org_ff [3];
   logic [31:0] scl_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            org_ff[i] <= '0;
            scl_ff[i] <= 32'd65536;
         end
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE:   en_ff <= csr_data[0];
            CSR_X_ORIGIN: org_ff[0] <= csr_data;
            CSR_Y_ORIGIN: org_ff[1] <= csr_data;
            CSR_Z_ORIGIN: org_ff[2] <= csr_data;
            CSR_X_SCALE:  scl_ff[0] <= csr_data;
            CSR_Y_SCALE:  scl_ff[1] <= csr_data;
            CSR_Z_SCALE:  scl_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // request word
   logic               act_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [31:0]        ent_ff [3];
   logic signed [31:0] pos_ff [3];
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         addr_ff <= req_entry_address;
         ent_ff[0] <= req_entry_x;
         ent_ff[1] <= req_entry_y;
         ent_ff[2] <= req_entry_z;
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
      end
   end

   // axis mapping: one multiply per axis, then range check
   logic signed [32:0] diff;
   logic [32:0]        mag;
   logic [64:0]        prod_ff;
   logic               neg_ff;
   logic [47:0]        coord;
   logic [47:0]        limit;
   logic               ok;
   logic [7:0]         lo_ff [3];
   logic [15:0]        fr_ff [3];
   logic               ok_ff;
   logic [7:0]         nm1;
   always_comb begin
      diff = 33'(pos_ff[cmd.map_axis]) - 33'($signed(org_ff[cmd.map_axis]));
      mag = diff[32] ? 33'(-diff) : diff;
      case (cmd.map_axis)
         2'd0: nm1 = 8'(GRID_NX - 1);
         2'd1: nm1 = 8'(GRID_NY - 1);
         default: nm1 = 8'(GRID_NZ - 1);
      endcase
      limit = {24'd0, nm1, 16'd0};
      coord = neg_ff ? 48'd0 : prod_ff[63:16];
      ok = (!neg_ff || prod_ff == '0) && !prod_ff[64] && coord <= limit;
   end
   always_ff @(posedge clock) begin
      if (cmd.map_mul) begin
         prod_ff <= 65'(mag) * 65'(scl_ff[cmd.map_axis]);
         neg_ff <= diff[32];
      end
      if (cmd.map_fin) begin
         lo_ff[cmd.map_axis] <= coord[23:16];
         fr_ff[cmd.map_axis] <= coord[15:0];
      end
      if (cmd.load) ok_ff <= 1'b1;
      else if (cmd.map_fin) ok_ff <= ok_ff & ok;
   end

   assign sts.is_sample = act_ff;
   assign sts.in_grid = en_ff & ok_ff;
   assign sts.interior = (32'(lo_ff[0]) + 1 < GRID_NX) && (32'(lo_ff[1]) + 1 < GRID_NY)
                         && (32'(lo_ff[2]) + 1 < GRID_NZ);

   // grid memory, corner bits {dx,dy,dz}
   logic [31:0] ax, ay, az, flat;
   logic [ADDR_W-1:0] ram_addr;
   always_comb begin
      ax = 32'(lo_ff[0]) + 32'(cmd.corner[2]);
      ay = 32'(lo_ff[1]) + 32'(cmd.corner[1]);
      az = 32'(lo_ff[2]) + 32'(cmd.corner[0]);
      flat = (ax * GRID_NY + ay) * GRID_NZ + az;
      ram_addr = cmd.do_write ? addr_ff : flat[ADDR_W-1:0];
   end
   logic [31:0] rd [3];
   for (genvar c = 0; c < 3; c++) begin : g_ram
      vfts_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_ram (
         .clock(clock), .we(cmd.do_write), .addr(ram_addr),
         .wdata(ent_ff[c]), .rdata(rd[c])
      );
   end

   // corner and partial results, one lerp step per cycle for all components once the last corner read is in
   logic signed [31:0] nd_ff [3][8];
   logic signed [31:0] pa [3], pb [3];
   logic signed [31:0] res [3];
   logic [15:0] f;
   logic signed [49:0] s [3];
   logic [49:0] sm [3];
   always_comb begin
      case (cmd.lerp_step)
         3'd0, 3'd1, 3'd2, 3'd3: f = fr_ff[2];
         3'd4, 3'd5: f = fr_ff[1];
         default: f = fr_ff[0];
      endcase
      for (int c = 0; c < 3; c++) begin
         case (cmd.lerp_step)
            3'd0: begin pa[c] = nd_ff[c][0]; pb[c] = nd_ff[c][1]; end
            3'd1: begin pa[c] = nd_ff[c][2]; pb[c] = nd_ff[c][3]; end
            3'd2: begin pa[c] = nd_ff[c][4]; pb[c] = nd_ff[c][5]; end
            3'd3: begin pa[c] = nd_ff[c][6]; pb[c] = nd_ff[c][7]; end
            3'd4: begin pa[c] = nd_ff[c][0]; pb[c] = nd_ff[c][2]; end
            3'd5: begin pa[c] = nd_ff[c][4]; pb[c] = nd_ff[c][6]; end
            default: begin pa[c] = nd_ff[c][0]; pb[c] = nd_ff[c][4]; end
         endcase
         s[c] = 50'(pa[c]) * $signed({1'b0, 17'(18'h10000 - 18'(f))})
              + 50'(pb[c]) * $signed({1'b0, 16'(f)});
         sm[c] = s[c][49] ? 50'(-s[c]) : 50'(s[c]);
         res[c] = s[c][49] ? 32'(-$signed({1'b0, sm[c][49:16]})) : 32'(sm[c][47:16]);
      end
   end
   logic [2:0] dst;
   always_comb begin
      case (cmd.lerp_step)
         3'd0: dst = 3'd0;
         3'd1: dst = 3'd2;
         3'd2: dst = 3'd4;
         3'd3: dst = 3'd6;
         3'd4: dst = 3'd0;
         3'd5: dst = 3'd4;
         default: dst = 3'd0;
      endcase
   end
   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.acc_en) nd_ff[c][cmd.acc_corner] <= rd[c];
         else if (cmd.lerp_en) nd_ff[c][dst] <= res[c];
      end
   end

   // result word
   logic strobe_ff;
   logic [31:0] o_ff [3];
   logic ins_ff;
   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= cmd.respond;
      if (cmd.respond) begin
         ins_ff <= sts.in_grid;
         for (int c = 0; c < 3; c++) o_ff[c] <= sts.in_grid ? nd_ff[c][0] : 32'd0;
      end
   end
   assign rsp_strobe = strobe_ff;
   assign rsp_out_x = o_ff[0];
   assign rsp_out_y = o_ff[1];
   assign rsp_out_z = o_ff[2];
   assign rsp_inside_res = ins_ff;
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
import vfts_pkg::*;

typedef struct {
   bit [31:0] vx;
   bit [31:0] vy;
   bit [31:0] vz;
   bit        in_grid;
} field_vec_type;

class field_scoreboard;
   bit signed [31:0] grid_mem[3][STORE_DEPTH];
   bit               written[STORE_DEPTH];
   bit               enable;
   bit [31:0]        origin[3];
   bit [31:0]        scale[3];
   int               dims[3];
   field_vec_type    expected_q[$];
   int               errors, writes, samples, insides;

   function new();
      dims[0] = GRID_NX_DEF;
      dims[1] = GRID_NY_DEF;
      dims[2] = GRID_NZ_DEF;
      enable = 0;
      foreach (origin[i]) begin
         origin[i] = 0;
         scale[i] = 32'd65536;
      end
   endfunction

   function void set_reg(bit [CSR_IDX_W-1:0] idx, bit [31:0] v);
      case (idx)
         CSR_ENABLE:   enable = v[0];
         CSR_X_ORIGIN: origin[0] = v;
         CSR_Y_ORIGIN: origin[1] = v;
         CSR_Z_ORIGIN: origin[2] = v;
         CSR_X_SCALE:  scale[0] = v;
         CSR_Y_SCALE:  scale[1] = v;
         CSR_Z_SCALE:  scale[2] = v;
         default: ;
      endcase
   endfunction

   // position to lower node and fraction; 0 when outside
   function bit map_axis(bit [31:0] pos, int ax, output int lo, output int fr);
      longint    diff;
      bit [63:0] c;
      lo = 0;
      fr = 0;
      diff = longint'(signed'(pos)) - longint'(signed'(origin[ax]));
      if (diff < 0) begin
         if (scale[ax] != 0) return 0;
         c = 0;
      end else begin
         c = 64'(diff) * 64'(scale[ax]);
         c = c >> 16;
      end
      if (c > (64'(dims[ax] - 1) << 16)) return 0;
      lo = int'(c >> 16);
      fr = int'(c[15:0]);
      return 1;
   endfunction

   function bit locate(bit [31:0] px, bit [31:0] py, bit [31:0] pz,
                       output int lo[3], output int fr[3]);
      bit ok;
      ok = enable;
      ok = ok && map_axis(px, 0, lo[0], fr[0]);
      ok = ok && map_axis(py, 1, lo[1], fr[1]);
      ok = ok && map_axis(pz, 2, lo[2], fr[2]);
      return ok;
   endfunction

   function bit interior(int lo[3]);
      return lo[0] + 1 < dims[0] && lo[1] + 1 < dims[1] && lo[2] + 1 < dims[2];
   endfunction

   function int node_addr(int x, int y, int z);
      return ((x * dims[1] + y) * dims[2] + z) & (STORE_DEPTH - 1);
   endfunction

   // grid entries that a sample at this position reads
   function void corners(bit [31:0] px, bit [31:0] py, bit [31:0] pz, ref int q[$]);
      int lo[3], fr[3];
      q = {};
      if (!locate(px, py, pz, lo, fr)) return;
      if (!interior(lo)) begin
         q.push_back(node_addr(lo[0], lo[1], lo[2]));
         return;
      end
      for (int k = 0; k < 8; k++)
         q.push_back(node_addr(lo[0] + k[2], lo[1] + k[1], lo[2] + k[0]));
   endfunction

   function longint blend(longint a, longint b, int f);
      longint s;
      s = a * (65536 - f) + b * f;
      if (s < 0) return -((-s) >> 16);
      return s >> 16;
   endfunction

   function longint node(int c, int x, int y, int z);
      return longint'(grid_mem[c][node_addr(x, y, z)]);
   endfunction

   // z first, then y, then x
   function longint trilinear(int c, int lo[3], int fr[3]);
      longint i1, i2, j1, j2;
      int x, y, z;
      x = lo[0];
      y = lo[1];
      z = lo[2];
      i1 = blend(node(c, x, y, z), node(c, x, y, z + 1), fr[2]);
      i2 = blend(node(c, x, y + 1, z), node(c, x, y + 1, z + 1), fr[2]);
      j1 = blend(node(c, x + 1, y, z), node(c, x + 1, y, z + 1), fr[2]);
      j2 = blend(node(c, x + 1, y + 1, z), node(c, x + 1, y + 1, z + 1), fr[2]);
      return blend(blend(i1, i2, fr[1]), blend(j1, j2, fr[1]), fr[0]);
   endfunction

   function void note(bit act, bit [ADDR_W-1:0] a, bit [31:0] ex, bit [31:0] ey,
                      bit [31:0] ez, bit [31:0] px, bit [31:0] py, bit [31:0] pz);
      int            lo[3], fr[3];
      longint        r[3];
      field_vec_type e;
      if (act == 1'b0) begin
         grid_mem[0][a] = ex;
         grid_mem[1][a] = ey;
         grid_mem[2][a] = ez;
         written[a] = 1;
         writes++;
         return;
      end
      samples++;
      r = '{0, 0, 0};
      e.in_grid = locate(px, py, pz, lo, fr);
      if (e.in_grid) begin
         insides++;
         for (int c = 0; c < 3; c++)
            r[c] = interior(lo) ? trilinear(c, lo, fr) : node(c, lo[0], lo[1], lo[2]);
      end
      e.vx = r[0][31:0];
      e.vy = r[1][31:0];
      e.vz = r[2][31:0];
      expected_q.push_back(e);
   endfunction

   function void check(bit [31:0] ox, bit [31:0] oy, bit [31:0] oz, bit ins);
      field_vec_type e;
      if (expected_q.size() == 0) begin
         $error("result word with no sample outstanding");
         errors++;
         return;
      end
      e = expected_q.pop_front();
      if (ins != e.in_grid) begin
         $error("inside_res: expected %0d, got %0d", e.in_grid, ins);
         errors++;
      end
      if (ox != e.vx) begin
         $error("out_x: expected %h, got %h", e.vx, ox);
         errors++;
      end
      if (oy != e.vy) begin
         $error("out_y: expected %h, got %h", e.vy, oy);
         errors++;
      end
      if (oz != e.vz) begin
         $error("out_z: expected %h, got %h", e.vz, oz);
         errors++;
      end
   endfunction
endclass

module tb;
   localparam bit ACT_WRITE = 1'b0;
   localparam bit ACT_SAMPLE = 1'b1;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE = 40;   // beyond the longest sample latency
   localparam int PHASE_ITEMS = 245;   // words per random phase, fills included

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic               req_action = 0;
   logic [ADDR_W-1:0]  req_entry_address = 0;
   logic signed [31:0] req_entry_x = 0;
   logic signed [31:0] req_entry_y = 0;
   logic signed [31:0] req_entry_z = 0;
   logic signed [31:0] req_pos_x = 0;
   logic signed [31:0] req_pos_y = 0;
   logic signed [31:0] req_pos_z = 0;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [31:0]        csr_data = 0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic               rsp_inside_res;

   field_scoreboard sb = new();
   int cycles = 0;
   int sent = 0;

   vector_field_trilinear_sampler dut (.*);

   always #4 clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result words cannot be stalled: take each one as it comes
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check(rsp_out_x, rsp_out_y, rsp_out_z, rsp_inside_res);
   end

   function automatic bit [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // position near the grid along one axis, now and then far away or just below
   function automatic bit [31:0] rand_pos(int ax);
      longint span, off;
      int     r;
      r = $urandom_range(0, 19);
      if (r < 2 || sb.scale[ax] == 0) return $urandom;
      if (r == 2) return sb.origin[ax] - $urandom_range(1, 5000);
      if (r == 3 && sb.scale[ax] == 32'd65536)
         return sb.origin[ax] + ($urandom_range(0, 31) << 16);
      span = (longint'(33) << 32) / sb.scale[ax];
      if (span > (longint'(1) << 31)) span = longint'(1) << 31;
      off = (longint'($urandom) * span) >> 32;
      return sb.origin[ax] + off[31:0];
   endfunction

   // hold start low for a while: mostly short, a few long stretches
   task automatic idle_gap();
      int g, r;
      r = $urandom_range(0, 99);
      g = (r < 50) ? 0 : (r < 88) ? $urandom_range(1, 3) : $urandom_range(5, 40);
      if (g > 0) begin
         start <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send(bit act, bit [ADDR_W-1:0] a, bit [31:0] ex, bit [31:0] ey,
                       bit [31:0] ez, bit [31:0] px, bit [31:0] py, bit [31:0] pz);
      start <= 1;
      req_action <= act;
      req_entry_address <= a;
      req_entry_x <= ex;
      req_entry_y <= ey;
      req_entry_z <= ez;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      do @(posedge clock); while (busy);
      sb.note(act, a, ex, ey, ez, px, py, pz);
      sent++;
      idle_gap();
   endtask

   task automatic write_entry(bit [ADDR_W-1:0] a, bit [31:0] ex, bit [31:0] ey,
                              bit [31:0] ez);
      send(ACT_WRITE, a, ex, ey, ez, $urandom, $urandom, $urandom);
   endtask

   // fill any corner never written, then sample
   task automatic sample_at(bit [31:0] px, bit [31:0] py, bit [31:0] pz);
      int q[$];
      sb.corners(px, py, pz, q);
      foreach (q[i])
         if (!sb.written[q[i]])
            write_entry(ADDR_W'(q[i]), rand_word(), rand_word(), rand_word());
      send(ACT_SAMPLE, ADDR_W'($urandom), $urandom, $urandom, $urandom, px, py, pz);
   endtask

   // drain: no sample outstanding and a trailing write finished
   task automatic drain();
      start <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(bit [CSR_IDX_W-1:0] idx, bit [31:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.set_reg(idx, v);
   endtask

   task automatic set_grid(bit en, bit [31:0] ox, bit [31:0] oy, bit [31:0] oz,
                           bit [31:0] sx, bit [31:0] sy, bit [31:0] sz);
      drain();
      csr_write(CSR_ENABLE, {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0, en});
      csr_write(CSR_X_ORIGIN, ox);
      csr_write(CSR_Y_ORIGIN, oy);
      csr_write(CSR_Z_ORIGIN, oz);
      csr_write(CSR_X_SCALE, sx);
      csr_write(CSR_Y_SCALE, sy);
      csr_write(CSR_Z_SCALE, sz);
   endtask

   initial begin
      int phase_end;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // disabled after reset: zero vector no matter where
      sample_at(0, 0, 0);
      sample_at(32'h0001_8000, 32'h0002_0000, 32'h0003_4000);
      write_entry(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);

      set_grid(1, 0, 0, 0, 32'd65536, 32'd65536, 32'd65536);
      // extreme entries around cell (1,1,1), then its center
      for (int k = 0; k < 8; k++)
         write_entry(ADDR_W'(sb.node_addr(1 + k[2], 1 + k[1], 1 + k[0])),
                     k[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                     k[1] ? 32'h8000_0000 : 32'h7FFF_FFFF, k[2] ? 32'hFFFF_FFFF : 32'h1);
      sample_at(32'h0001_8000, 32'h0001_8000, 32'h0001_8000);
      sample_at(32'h0001_FFFF, 32'h0001_0001, 32'h0001_C000);
      sample_at(0, 0, 0);                                  // grid minimum
      sample_at(32'h001F_0000, 32'h001F_0000, 32'h001F_0000); // last node
      sample_at(32'h001F_0000, 32'h0004_8000, 32'h0007_2000); // last node on x only
      sample_at(32'h001F_0001, 32'h0001_0000, 32'h0001_0000); // just past the top
      sample_at(32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000); // just below the bottom
      sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      sample_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      sample_at(32'h0005_8000, 32'h0007_4000, 32'h001E_FFFF);

      // zero scale maps every position to node 0; full scale saturates out fast
      set_grid(1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'd65536);
      sample_at(32'h1234_0000, 32'h7FFF_FFFF, 32'h0002_8000);
      sample_at(32'h8000_0000, 32'h8000_0000, 32'h0000_4000);
      sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h001E_8000);

      // random phases, each under its own grid placement
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_grid(1, $urandom_range(0, 200000) - 100000,
                        $urandom_range(0, 200000) - 100000,
                        $urandom_range(0, 200000) - 100000,
                        32'd65536, 32'd65536, 32'd65536);
            1: set_grid(1, $urandom, $urandom, $urandom, $urandom_range(4096, 1 << 20),
                        $urandom_range(4096, 1 << 20), $urandom_range(4096, 1 << 20));
            2: set_grid(1, 32'h8000_0000, 32'hFFFF_0000, 32'h7FFF_0000,
                        0, 32'hFFFF_FFFF, 32'd65536 << 3);
            3: set_grid(0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            4: set_grid(1, $urandom, $urandom, $urandom, $urandom_range(1, 32'hFFFF_FFFF),
                        32'd16384, $urandom_range(1, 32'hFFFF_FFFF));
            default: set_grid(1, 0, 0, 0, 32'd65536, 32'd65536, 32'd65536);
         endcase
         phase_end = sent + PHASE_ITEMS;
         while (sent < phase_end) begin
            if ($urandom_range(0, 9) == 0)
               write_entry(ADDR_W'($urandom), rand_word(), rand_word(), rand_word());
            sample_at(rand_pos(0), rand_pos(1), rand_pos(2));
         end
      end

      drain();
      $display("covered %0d grid writes and %0d samples, %0d of them inside the grid",
               sb.writes, sb.samples, sb.insides);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
